// File: hdl/ffpa_pkg.sv
package ffpa_pkg;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam int REQ_W       = 17;
  localparam int OFF_W       = 16;
  localparam int NEED_W      = 18;
  localparam int ALIGN_BYTES = 4;

endpackage

// File: hdl/ffpa_hdr_ram.sv
module ffpa_hdr_ram #(
  parameter int DEPTH = 16384,
  parameter int DW    = 18,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/first_fit_pool_allocator_unit.sv
// First-fit pool allocator with coalescing. Block headers ({free, payload size}) live in one
// synchronous RAM indexed by the block's byte position divided by 4; the chain is walked
// from offset zero one header per cycle, the next address coming from the header just read.
// A transaction is accepted from idle, visits blocks in ST_WALK up to and including the fit
// or match, and passes through ST_SPLIT for an allocate that splits a block, or ST_FNEXT for
// a free whose block has a successor, before the out_valid strobe is registered.
// busy stays high until the result is issued. out_valid is a one-cycle
// strobe that cannot be held off, so the receiver must capture the result in that cycle.
// After reset the unit writes the initial header in ST_INIT before it accepts work.
module first_fit_pool_allocator_unit #(
  parameter int POOL_BYTES   = 65536,
  parameter int HEADER_BYTES = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_func,
  input  logic [ffpa_pkg::REQ_W-1:0] in_request_bytes,
  input  logic [ffpa_pkg::OFF_W-1:0] in_payload_offset,
  output logic                      out_valid,
  output logic [ffpa_pkg::OFF_W-1:0] out_granted_offset,
  output logic                      out_success
);

  localparam int PW    = $clog2(POOL_BYTES + 1);
  localparam int NW    = ffpa_pkg::NEED_W;
  localparam int WW    = ((PW > NW) ? PW : NW) + 2;
  localparam int DEPTH = (POOL_BYTES + 3) / 4;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = PW + 1;

  localparam logic [WW-1:0] HDR_W  = WW'(HEADER_BYTES);
  localparam logic [WW-1:0] POOL_W = WW'(POOL_BYTES);
  localparam logic [PW-1:0] INIT_SIZE = PW'(POOL_BYTES - HEADER_BYTES);
  localparam logic [NW-1:0] ALIGN_M  = NW'(ffpa_pkg::ALIGN_BYTES - 1);

  typedef enum logic [2:0] {ST_INIT, ST_IDLE, ST_WALK, ST_SPLIT, ST_FNEXT} state_t;

  function automatic logic [AW-1:0] addr_of(input logic [WW-1:0] p);
    return p[AW+1:2];
  endfunction

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  logic                     func_r, func_nxt;
  logic [NW-1:0]            need_r, need_nxt;
  logic [ffpa_pkg::OFF_W-1:0] target_r, target_nxt;
  logic [PW-1:0]            pos_r, pos_nxt;
  logic [PW-1:0]            prev_pos_r, prev_pos_nxt;
  logic [PW-1:0]            prev_size_r, prev_size_nxt;
  logic                     prev_free_r, prev_free_nxt;
  logic                     prev_valid_r, prev_valid_nxt;
  logic [PW-1:0]            cur_size_r, cur_size_nxt;
  logic [AW-1:0]            split_addr_r, split_addr_nxt;
  logic [DW-1:0]            split_data_r, split_data_nxt;
  logic [ffpa_pkg::OFF_W-1:0] gnt_r, gnt_nxt;
  logic [ffpa_pkg::OFF_W-1:0] out_off_r, out_off_nxt;
  logic                     out_succ_r, out_succ_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [DW-1:0] rd_data;

  logic          rd_free;
  logic [PW-1:0] rd_size;
  logic [WW-1:0] pos_w, size_w, need_w, npos_w, gpos_w, split_pos_w, rest_w, msize_w;
  logic          at_end, fit, split, match, pm, nf;
  logic [PW-1:0] m_cur_size;

  ffpa_hdr_ram #(
    .DEPTH(DEPTH),
    .DW   (DW)
  ) u_hdr_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(rd_data)
  );

  assign busy               = (state_r != ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_granted_offset = out_off_r;
  assign out_success        = out_succ_r;

  assign rd_free     = rd_data[PW];
  assign rd_size     = rd_data[PW-1:0];
  assign pos_w       = WW'(pos_r);
  assign size_w      = WW'(rd_size);
  assign need_w      = WW'(need_r);
  assign npos_w      = pos_w + HDR_W + size_w;
  assign gpos_w      = pos_w + HDR_W;
  assign split_pos_w = gpos_w + need_w;
  assign rest_w      = size_w - HDR_W - need_w;
  assign at_end      = (npos_w >= POOL_W);
  assign fit         = rd_free && (size_w >= need_w);
  assign split       = (size_w > need_w + HDR_W);
  assign match       = (gpos_w == WW'(target_r));

  // coalesce with free neighbors
  assign pm         = prev_valid_r && prev_free_r;
  assign nf         = (state_r == ST_FNEXT) && rd_free;
  assign m_cur_size = (state_r == ST_FNEXT) ? cur_size_r : rd_size;
  assign msize_w    = (pm ? WW'(prev_size_r) + HDR_W : '0) + WW'(m_cur_size)
                    + (nf ? size_w + HDR_W : '0);

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = 1'b0;
    func_nxt       = func_r;
    need_nxt       = need_r;
    target_nxt     = target_r;
    pos_nxt        = pos_r;
    prev_pos_nxt   = prev_pos_r;
    prev_size_nxt  = prev_size_r;
    prev_free_nxt  = prev_free_r;
    prev_valid_nxt = prev_valid_r;
    cur_size_nxt   = cur_size_r;
    split_addr_nxt = split_addr_r;
    split_data_nxt = split_data_r;
    gnt_nxt        = gnt_r;
    out_off_nxt    = out_off_r;
    out_succ_nxt   = out_succ_r;
    ram_we         = 1'b0;
    ram_waddr      = addr_of(pos_w);
    ram_wdata      = '0;
    ram_raddr      = '0;

    case (state_r)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = {1'b1, INIT_SIZE};
        state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          func_nxt       = in_func;
          need_nxt       = (NW'(in_request_bytes) + ALIGN_M) & ~ALIGN_M;
          target_nxt     = in_payload_offset;
          pos_nxt        = '0;
          prev_valid_nxt = 1'b0;
          ram_raddr      = '0;
          state_nxt      = ST_WALK;
        end
      end
      ST_WALK: begin
        if (func_r == ffpa_pkg::FUNC_ALLOC && fit) begin
          ram_we    = 1'b1;
          ram_wdata = {1'b0, split ? need_w[PW-1:0] : rd_size};
          if (split) begin
            split_addr_nxt = addr_of(split_pos_w);
            split_data_nxt = {1'b1, rest_w[PW-1:0]};
            gnt_nxt        = gpos_w[ffpa_pkg::OFF_W-1:0];
            state_nxt      = ST_SPLIT;
          end else begin
            out_valid_nxt = 1'b1;
            out_off_nxt   = gpos_w[ffpa_pkg::OFF_W-1:0];
            out_succ_nxt  = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else if (func_r == ffpa_pkg::FUNC_FREE && match) begin
          if (at_end) begin
            ram_we        = 1'b1;
            ram_waddr     = pm ? addr_of(WW'(prev_pos_r)) : addr_of(pos_w);
            ram_wdata     = {1'b1, msize_w[PW-1:0]};
            out_valid_nxt = 1'b1;
            out_off_nxt   = '0;
            out_succ_nxt  = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            ram_raddr    = addr_of(npos_w);
            cur_size_nxt = rd_size;
            state_nxt    = ST_FNEXT;
          end
        end else if (at_end) begin
          out_valid_nxt = 1'b1;
          out_off_nxt   = '0;
          out_succ_nxt  = 1'b0;
          state_nxt     = ST_IDLE;
        end else begin
          ram_raddr      = addr_of(npos_w);
          pos_nxt        = npos_w[PW-1:0];
          prev_pos_nxt   = pos_r;
          prev_size_nxt  = rd_size;
          prev_free_nxt  = rd_free;
          prev_valid_nxt = 1'b1;
        end
      end
      ST_SPLIT: begin
        ram_we        = 1'b1;
        ram_waddr     = split_addr_r;
        ram_wdata     = split_data_r;
        out_valid_nxt = 1'b1;
        out_off_nxt   = gnt_r;
        out_succ_nxt  = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_FNEXT: begin
        ram_we        = 1'b1;
        ram_waddr     = pm ? addr_of(WW'(prev_pos_r)) : addr_of(pos_w);
        ram_wdata     = {1'b1, msize_w[PW-1:0]};
        out_valid_nxt = 1'b1;
        out_off_nxt   = '0;
        out_succ_nxt  = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      out_valid_r <= 1'b0;
      out_off_r   <= '0;
      out_succ_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      out_off_r   <= out_off_nxt;
      out_succ_r  <= out_succ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    need_r       <= need_nxt;
    target_r     <= target_nxt;
    pos_r        <= pos_nxt;
    prev_pos_r   <= prev_pos_nxt;
    prev_size_r  <= prev_size_nxt;
    prev_free_r  <= prev_free_nxt;
    prev_valid_r <= prev_valid_nxt;
    cur_size_r   <= cur_size_nxt;
    split_addr_r <= split_addr_nxt;
    split_data_r <= split_data_nxt;
    gnt_r        <= gnt_nxt;
  end

  a_fail_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_success || out_granted_offset == '0))
    else $error("failed transaction reports a nonzero offset");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !ram_we)
    else $error("header RAM written while idle");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_free_no_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && func_r == ffpa_pkg::FUNC_FREE) |-> (out_granted_offset == '0))
    else $error("free transaction reports an offset");

endmodule

// File: tb/ffpa_grant_checker.sv
module ffpa_grant_checker #(
  parameter int POOL_BYTES   = 65536,
  parameter int HEADER_BYTES = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  logic                       in_func,
  input  logic [ffpa_pkg::REQ_W-1:0] in_request_bytes,
  input  logic [ffpa_pkg::OFF_W-1:0] in_payload_offset,
  input  logic                       out_valid,
  input  logic [ffpa_pkg::OFF_W-1:0] out_granted_offset,
  input  logic                       out_success,
  output int                         fail_count,
  output int                         open_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic                        free;
    logic [ffpa_pkg::NEED_W-1:0] size;
  } block_hdr_t;

  typedef struct {
    logic [ffpa_pkg::OFF_W-1:0] offset;
    logic                       success;
  } grant_t;

  block_hdr_t block_chain[$];
  grant_t     expected_grants[$];

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  function automatic void reset_chain();
    block_hdr_t whole;
    whole.free = 1'b1;
    whole.size = ffpa_pkg::NEED_W'(POOL_BYTES - HEADER_BYTES);
    block_chain = {};
    block_chain.push_back(whole);
  endfunction

  // First-fit walk over the header chain; updates the chain as the block does.
  function automatic grant_t serve_request(logic func, logic [ffpa_pkg::REQ_W-1:0] req,
                                           logic [ffpa_pkg::OFF_W-1:0] target);
    grant_t      g;
    block_hdr_t  spare;
    int unsigned need;
    int unsigned pos;
    int          k;
    g.offset  = '0;
    g.success = 1'b0;
    pos       = 0;
    if (func == ffpa_pkg::FUNC_ALLOC) begin
      need = (req + ffpa_pkg::ALIGN_BYTES - 1) / ffpa_pkg::ALIGN_BYTES * ffpa_pkg::ALIGN_BYTES;
      for (int i = 0; i < block_chain.size(); i++) begin
        if (block_chain[i].free && block_chain[i].size >= need) begin
          if (block_chain[i].size > need + HEADER_BYTES) begin
            spare.free = 1'b1;
            spare.size = ffpa_pkg::NEED_W'(block_chain[i].size - HEADER_BYTES - need);
            block_chain.insert(i + 1, spare);
            block_chain[i].size = ffpa_pkg::NEED_W'(need);
          end
          block_chain[i].free = 1'b0;
          g.offset  = ffpa_pkg::OFF_W'(pos + HEADER_BYTES);
          g.success = 1'b1;
          return g;
        end
        pos += HEADER_BYTES + block_chain[i].size;
      end
    end else begin
      for (int i = 0; i < block_chain.size(); i++) begin
        if (pos + HEADER_BYTES == target) begin
          k = i;
          block_chain[k].free = 1'b1;
          if (k > 0 && block_chain[k-1].free) begin
            block_chain[k-1].size += block_chain[k].size + HEADER_BYTES;
            block_chain.delete(k);
            k--;
          end
          if (k + 1 < block_chain.size() && block_chain[k+1].free) begin
            block_chain[k].size += block_chain[k+1].size + HEADER_BYTES;
            block_chain.delete(k + 1);
          end
          g.success = 1'b1;
          return g;
        end
        pos += HEADER_BYTES + block_chain[i].size;
      end
    end
    return g;
  endfunction

  always @(posedge clk) begin
    grant_t want;
    if (!rst_n) begin
      reset_chain();
      expected_grants = {};
    end else begin
      if (out_valid) begin
        if (expected_grants.size() == 0) begin
          report_mismatch("result strobe with no transaction outstanding");
        end else begin
          want = expected_grants.pop_front();
          if (out_granted_offset !== want.offset)
            report_mismatch($sformatf("granted_offset got %0d want %0d",
                                      out_granted_offset, want.offset));
          if (out_success !== want.success)
            report_mismatch($sformatf("success got %b want %b",
                                      out_success, want.success));
        end
      end
      if (start && !busy)
        expected_grants.push_back(serve_request(in_func, in_request_bytes,
                                                in_payload_offset));
    end
    open_count <= expected_grants.size();
  end

endmodule

// File: tb/tb_first_fit_pool_allocator_unit.sv
module tb_first_fit_pool_allocator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int POOL_BYTES   = 65536;
  localparam int HEADER_BYTES = 8;
  localparam int MAX_LIVE     = 48;
  localparam int RANDOM_ITEMS = 1480;

  logic                       clk               = 1'b0;
  logic                       rst_n             = 1'b0;
  logic                       start             = 1'b0;
  logic                       in_func           = ffpa_pkg::FUNC_ALLOC;
  logic [ffpa_pkg::REQ_W-1:0] in_request_bytes  = '0;
  logic [ffpa_pkg::OFF_W-1:0] in_payload_offset = '0;
  logic                       busy;
  logic                       out_valid;
  logic [ffpa_pkg::OFF_W-1:0] out_granted_offset;
  logic                       out_success;
  int                         fail_count;
  int                         open_count;

  logic [ffpa_pkg::OFF_W-1:0] live_offsets[$];
  logic [ffpa_pkg::OFF_W-1:0] last_freed = '0;
  bit                         no_gaps    = 1'b0;
  bit                         draining   = 1'b0;

  first_fit_pool_allocator_unit #(
    .POOL_BYTES  (POOL_BYTES),
    .HEADER_BYTES(HEADER_BYTES)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_func           (in_func),
    .in_request_bytes  (in_request_bytes),
    .in_payload_offset (in_payload_offset),
    .out_valid         (out_valid),
    .out_granted_offset(out_granted_offset),
    .out_success       (out_success)
  );

  ffpa_grant_checker #(
    .POOL_BYTES  (POOL_BYTES),
    .HEADER_BYTES(HEADER_BYTES)
  ) u_grant_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_func           (in_func),
    .in_request_bytes  (in_request_bytes),
    .in_payload_offset (in_payload_offset),
    .out_valid         (out_valid),
    .out_granted_offset(out_granted_offset),
    .out_success       (out_success),
    .fail_count        (fail_count),
    .open_count        (open_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAIL first_fit_pool_allocator_unit");
    $finish;
  end

  // One transaction: hold start until accepted, then wait for its result strobe.
  task automatic issue(logic f, int unsigned value);
    start <= 1'b1;
    in_func <= f;
    if (f == ffpa_pkg::FUNC_ALLOC) begin
      in_request_bytes  <= ffpa_pkg::REQ_W'(value);
      in_payload_offset <= ffpa_pkg::OFF_W'($urandom);
    end else begin
      in_request_bytes  <= ffpa_pkg::REQ_W'($urandom_range(0, 65536));
      in_payload_offset <= ffpa_pkg::OFF_W'(value);
    end
    do @(posedge clk); while (busy);
    start <= 1'b0;
    do @(posedge clk); while (!out_valid);
    if (f == ffpa_pkg::FUNC_ALLOC && out_success)
      live_offsets.push_back(out_granted_offset);
  endtask

  task automatic idle_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) n = 0;
    else if (r < 90) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 60);
    repeat (n) begin
      in_func           <= 1'($urandom_range(0, 1));
      in_request_bytes  <= ffpa_pkg::REQ_W'($urandom_range(0, 65536));
      in_payload_offset <= ffpa_pkg::OFF_W'($urandom);
      @(posedge clk);
    end
  endtask

  function automatic int unsigned pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 64);
    if (r < 93) return $urandom_range(65, 2048);
    if (r < 97) return $urandom_range(2049, 20000);
    return $urandom_range(20001, 65536);
  endfunction

  task automatic free_live();
    int idx;
    idx = $urandom_range(0, live_offsets.size() - 1);
    last_freed = live_offsets[idx];
    live_offsets.delete(idx);
    issue(ffpa_pkg::FUNC_FREE, last_freed);
  endtask

  task automatic free_noise();
    int r;
    r = $urandom_range(0, 2);
    if (r == 0 || live_offsets.size() == 0)
      issue(ffpa_pkg::FUNC_FREE, $urandom_range(0, 65535));
    else if (r == 1) issue(ffpa_pkg::FUNC_FREE, live_offsets[0] + 4);
    else issue(ffpa_pkg::FUNC_FREE, last_freed);
  endtask

  initial begin
    int r;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: pool extremes, rounding, split boundary, coalescing
    issue(ffpa_pkg::FUNC_ALLOC, 65536);
    issue(ffpa_pkg::FUNC_FREE, 8);
    issue(ffpa_pkg::FUNC_FREE, 0);
    issue(ffpa_pkg::FUNC_FREE, 65535);
    issue(ffpa_pkg::FUNC_ALLOC, 65528);
    issue(ffpa_pkg::FUNC_ALLOC, 0);
    issue(ffpa_pkg::FUNC_FREE, 8);
    issue(ffpa_pkg::FUNC_ALLOC, 65521);
    issue(ffpa_pkg::FUNC_FREE, 8);
    issue(ffpa_pkg::FUNC_ALLOC, 65520);
    issue(ffpa_pkg::FUNC_FREE, 8);
    issue(ffpa_pkg::FUNC_ALLOC, 65516);
    issue(ffpa_pkg::FUNC_FREE, 8);
    issue(ffpa_pkg::FUNC_ALLOC, 0);
    issue(ffpa_pkg::FUNC_ALLOC, 1);
    issue(ffpa_pkg::FUNC_ALLOC, 3);
    issue(ffpa_pkg::FUNC_ALLOC, 4);
    issue(ffpa_pkg::FUNC_ALLOC, 5);
    issue(ffpa_pkg::FUNC_FREE, 16);
    issue(ffpa_pkg::FUNC_FREE, 40);
    issue(ffpa_pkg::FUNC_FREE, 28);
    issue(ffpa_pkg::FUNC_FREE, 52);
    issue(ffpa_pkg::FUNC_FREE, 8);
    live_offsets.delete();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 120 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if (live_offsets.size() == 0) draining = 1'b0;
      else if ($urandom_range(0, 99) == 0) draining = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 8) free_noise();
      else if (live_offsets.size() > 0 &&
               (draining || live_offsets.size() >= MAX_LIVE || r < 45)) free_live();
      else issue(ffpa_pkg::FUNC_ALLOC, pick_size());
      idle_gap();
    end

    while (open_count != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && open_count == 0) begin
      $display("PASS first_fit_pool_allocator_unit");
    end else begin
      $display("FAIL first_fit_pool_allocator_unit");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/ffpa_pkg.sv
hdl/ffpa_hdr_ram.sv
hdl/first_fit_pool_allocator_unit.sv
tb/ffpa_grant_checker.sv
tb/tb_first_fit_pool_allocator_unit.sv
